// ----- rtl/dlms_response_header_parser_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DLMS_RESPONSE_HEADER_PARSER_TOP_DEFINES_SVH
`define DLMS_RESPONSE_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DLMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dlms check failed");

// Next-cycle implication, disabled while reset is held.
`define DLMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dlms check failed");

`endif

// ----- rtl/dlms_rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// dlms_rhp_pkg
// Types, codes and lookup functions for the DLMS response header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlms_rhp_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_GET_TAG    = 2'd0;
    localparam logic [1:0] REG_SET_TAG    = 2'd1;
    localparam logic [1:0] REG_ACTION_TAG = 2'd2;
    localparam logic [1:0] REG_EXC_TAG    = 2'd3;

    localparam logic [7:0] GET_TAG_RST    = 8'd196;
    localparam logic [7:0] SET_TAG_RST    = 8'd197;
    localparam logic [7:0] ACTION_TAG_RST = 8'd199;
    localparam logic [7:0] EXC_TAG_RST    = 8'd216;

    localparam logic [2:0] SVC_NONE = 3'd0;
    localparam logic [2:0] SVC_GET  = 3'd1;
    localparam logic [2:0] SVC_SET  = 3'd2;
    localparam logic [2:0] SVC_ACT  = 3'd3;
    localparam logic [2:0] SVC_EXC  = 3'd4;

    localparam logic [1:0] FORM_OTHER  = 2'd0;
    localparam logic [1:0] FORM_NORMAL = 2'd1;
    localparam logic [1:0] FORM_BLOCK  = 2'd2;

    localparam logic [7:0] RESP_TYPE_NORMAL = 8'd1;
    localparam logic [7:0] RESP_TYPE_BLOCK  = 8'd2;
    localparam logic [7:0] CHOICE_DATA      = 8'd0;
    localparam logic [7:0] CHOICE_RESULT    = 8'd1;
    localparam logic [7:0] GDR_ABSENT       = 8'd0;
    localparam logic [7:0] GDR_PRESENT      = 8'd1;

    localparam logic [8:0] ACCESS_NOT_SET = 9'd256;
    localparam logic [8:0] ACCESS_SUCCESS = 9'd0;

    typedef struct packed {
        logic [7:0] get_tag;
        logic [7:0] set_tag;
        logic [7:0] action_tag;
        logic [7:0] exc_tag;
    } tags_t;

    typedef struct packed {
        logic        header_valid;
        logic [2:0]  service_kind;
        logic [1:0]  response_form;
        logic [7:0]  invoke_byte;
        logic [8:0]  access_code;
        logic [7:0]  action_code;
        logic        data_follows;
        logic [7:0]  last_block_flag;
        logic [31:0] block_num;
        logic [7:0]  state_error;
        logic [7:0]  service_error;
        logic        more_blocks;
    } result_t;

    function automatic logic known_access(input logic [7:0] code);
        logic hit;
        case (code) inside
            [8'd0:8'd4], 8'd9, [8'd11:8'd19], 8'd250: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic known_action(input logic [7:0] code);
        logic hit;
        case (code) inside
            [8'd0:8'd4], 8'd9, [8'd11:8'd16], 8'd250: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/dlms_rhp_cfg.sv -----
// ----------------------------------------------------------------------------
// dlms_rhp_cfg
// APB register bank holding the four service tag bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlms_rhp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dlms_rhp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dlms_rhp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dlms_rhp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output dlms_rhp_pkg::tags_t                 tags
);
    import dlms_rhp_pkg::*;

    tags_t      tags_reg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic [7:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tags_reg.get_tag    <= GET_TAG_RST;
            tags_reg.set_tag    <= SET_TAG_RST;
            tags_reg.action_tag <= ACTION_TAG_RST;
            tags_reg.exc_tag    <= EXC_TAG_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GET_TAG:    tags_reg.get_tag    <= pwdata[7:0];
                REG_SET_TAG:    tags_reg.set_tag    <= pwdata[7:0];
                REG_ACTION_TAG: tags_reg.action_tag <= pwdata[7:0];
                REG_EXC_TAG:    tags_reg.exc_tag    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GET_TAG:    rd_byte = tags_reg.get_tag;
            REG_SET_TAG:    rd_byte = tags_reg.set_tag;
            REG_ACTION_TAG: rd_byte = tags_reg.action_tag;
            REG_EXC_TAG:    rd_byte = tags_reg.exc_tag;
            default:        rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_byte};
    assign tags   = tags_reg;

endmodule

// ----- rtl/dlms_rhp_decoder.sv -----
// ----------------------------------------------------------------------------
// dlms_rhp_decoder
// Per-byte parse state machine; one byte is consumed on each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlms_rhp_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  dlms_rhp_pkg::tags_t   tags,
    output logic                  emit,
    output dlms_rhp_pkg::result_t result
);
    import dlms_rhp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TYPE,
        PH_INVOKE,
        PH_RESULT,
        PH_GDR_FLAG,
        PH_CHOICE,
        PH_ACCESS,
        PH_LAST_BLOCK,
        PH_BLOCK,
        PH_EXC_STATE,
        PH_EXC_SERVICE
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic        done_reg,       done_next;
    logic [2:0]  service_reg,    service_next;
    logic [1:0]  form_reg,       form_next;
    logic [7:0]  invoke_reg,     invoke_next;
    logic [8:0]  access_reg,     access_next;
    logic [7:0]  action_reg,     action_next;
    logic        data_flag_reg,  data_flag_next;
    logic [7:0]  last_block_reg, last_block_next;
    logic [31:0] block_reg,      block_next;
    logic [1:0]  count_reg,      count_next;
    logic [7:0]  state_err_reg,  state_err_next;

    logic        fin;
    logic        ok;
    logic [7:0]  svc_err;
    logic        live;

    always_comb begin
        phase_next      = phase_reg;
        done_next       = done_reg;
        service_next    = service_reg;
        form_next       = form_reg;
        invoke_next     = invoke_reg;
        access_next     = access_reg;
        action_next     = action_reg;
        data_flag_next  = data_flag_reg;
        last_block_next = last_block_reg;
        block_next      = block_reg;
        count_next      = count_reg;
        state_err_next  = state_err_reg;
        fin             = 1'b0;
        ok              = 1'b0;
        svc_err         = 8'd0;
        live            = step && (first_byte || !done_reg);

        if (first_byte) begin
            phase_next      = PH_IDLE;
            done_next       = 1'b0;
            service_next    = SVC_NONE;
            form_next       = FORM_OTHER;
            invoke_next     = 8'd0;
            access_next     = ACCESS_NOT_SET;
            action_next     = 8'd0;
            data_flag_next  = 1'b0;
            last_block_next = 8'd0;
            block_next      = 32'd0;
            count_next      = 2'd0;
            state_err_next  = 8'd0;
        end

        if (live) begin
            case (phase_next)
                PH_IDLE: begin
                    if (data_byte == tags.get_tag) begin
                        service_next = SVC_GET;
                        phase_next   = PH_TYPE;
                    end else if (data_byte == tags.set_tag) begin
                        service_next = SVC_SET;
                        phase_next   = PH_TYPE;
                    end else if (data_byte == tags.action_tag) begin
                        service_next = SVC_ACT;
                        phase_next   = PH_TYPE;
                    end else if (data_byte == tags.exc_tag) begin
                        service_next = SVC_EXC;
                        phase_next   = PH_EXC_STATE;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_TYPE: begin
                    if (data_byte == RESP_TYPE_NORMAL) form_next = FORM_NORMAL;
                    else if (data_byte == RESP_TYPE_BLOCK) form_next = FORM_BLOCK;
                    else form_next = FORM_OTHER;
                    phase_next = PH_INVOKE;
                end
                PH_INVOKE: begin
                    invoke_next = data_byte;
                    if (form_next == FORM_NORMAL) phase_next = PH_RESULT;
                    else if (form_next == FORM_BLOCK) phase_next = PH_LAST_BLOCK;
                    else begin
                        fin = 1'b1;
                        ok  = 1'b1;
                    end
                end
                PH_RESULT: begin
                    if (service_next == SVC_ACT) begin
                        if (known_action(data_byte)) begin
                            action_next = data_byte;
                            phase_next  = PH_GDR_FLAG;
                        end else begin
                            fin = 1'b1;
                        end
                    end else begin
                        fin = 1'b1;
                        if (known_access(data_byte)) begin
                            access_next = {1'b0, data_byte};
                            ok          = 1'b1;
                        end else begin
                            access_next = ACCESS_NOT_SET;
                        end
                    end
                end
                PH_GDR_FLAG: begin
                    if (data_byte == GDR_ABSENT) begin
                        fin = 1'b1;
                        ok  = 1'b1;
                    end else if (data_byte == GDR_PRESENT) begin
                        phase_next = PH_CHOICE;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_CHOICE: begin
                    if (data_byte == CHOICE_DATA) begin
                        data_flag_next = 1'b1;
                        access_next    = ACCESS_SUCCESS;
                        fin            = 1'b1;
                        ok             = 1'b1;
                    end else if (data_byte == CHOICE_RESULT) begin
                        phase_next = PH_ACCESS;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_ACCESS: begin
                    fin = 1'b1;
                    if (known_access(data_byte)) begin
                        access_next = {1'b0, data_byte};
                        ok          = 1'b1;
                    end
                end
                PH_LAST_BLOCK: begin
                    last_block_next = data_byte;
                    count_next      = 2'd0;
                    phase_next      = PH_BLOCK;
                end
                PH_BLOCK: begin
                    block_next = {block_next[23:0], data_byte};
                    if (count_next == 2'd3) begin
                        access_next = ACCESS_SUCCESS;
                        fin         = 1'b1;
                        ok          = 1'b1;
                    end else begin
                        count_next = count_next + 2'd1;
                    end
                end
                PH_EXC_STATE: begin
                    state_err_next = data_byte;
                    phase_next     = PH_EXC_SERVICE;
                end
                PH_EXC_SERVICE: begin
                    svc_err = data_byte;
                    fin     = 1'b1;
                    ok      = 1'b1;
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
            if (last_byte) fin = 1'b1;
            if (fin) begin
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b1;
        end else if (step) begin
            phase_reg      <= phase_next;
            done_reg       <= done_next;
            service_reg    <= service_next;
            form_reg       <= form_next;
            invoke_reg     <= invoke_next;
            access_reg     <= access_next;
            action_reg     <= action_next;
            data_flag_reg  <= data_flag_next;
            last_block_reg <= last_block_next;
            block_reg      <= block_next;
            count_reg      <= count_next;
            state_err_reg  <= state_err_next;
        end
    end

    assign emit = live && fin;

    always_comb begin
        result.header_valid    = ok;
        result.service_kind    = service_next;
        result.response_form   = form_next;
        result.invoke_byte     = invoke_next;
        result.access_code     = access_next;
        result.action_code     = action_next;
        result.data_follows    = data_flag_next;
        result.last_block_flag = last_block_next;
        result.block_num       = block_next;
        result.state_error     = state_err_next;
        result.service_error   = svc_err;
        result.more_blocks     = ok && (form_next == FORM_BLOCK) && (last_block_next == 8'd0);
    end

endmodule

// ----- rtl/dlms_response_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// dlms_response_header_parser_top
// DLMS/COSEM response APDU header parser with APB tag registers.
// ----------------------------------------------------------------------------
// Accepts one APDU byte per cycle while no result is held by m_ready low, and
// returns at most one summary transfer per APDU. A byte is captured in an
// input register at its transfer edge and decoded against the parse state
// once it can advance; any summary is then loaded into the result register,
// which drives m_valid. The input stage only waits while a result is held by
// m_ready low.
`timescale 1ns / 1ps

module dlms_response_header_parser_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_first_byte,
    input  logic                                s_last_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_header_valid,
    output logic [2:0]                          m_service_kind,
    output logic [1:0]                          m_response_form,
    output logic [7:0]                          m_invoke_byte,
    output logic [8:0]                          m_access_code,
    output logic [7:0]                          m_action_code,
    output logic                                m_data_follows,
    output logic [7:0]                          m_last_block_flag,
    output logic [31:0]                         m_block_num,
    output logic [7:0]                          m_state_error,
    output logic [7:0]                          m_service_error,
    output logic                                m_more_blocks,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dlms_rhp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dlms_rhp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dlms_rhp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import dlms_rhp_pkg::*;

    tags_t      tags;
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       advance;
    logic       emit;
    result_t    dec_result;
    logic       out_valid_reg;
    result_t    out_reg;

    dlms_rhp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tags    (tags)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_last_reg  <= s_last_byte;
        end
    end

    dlms_rhp_decoder u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .tags       (tags),
        .emit       (emit),
        .result     (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (emit) begin
            out_reg <= dec_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_header_valid    = out_reg.header_valid;
    assign m_service_kind    = out_reg.service_kind;
    assign m_response_form   = out_reg.response_form;
    assign m_invoke_byte     = out_reg.invoke_byte;
    assign m_access_code     = out_reg.access_code;
    assign m_action_code     = out_reg.action_code;
    assign m_data_follows    = out_reg.data_follows;
    assign m_last_block_flag = out_reg.last_block_flag;
    assign m_block_num       = out_reg.block_num;
    assign m_state_error     = out_reg.state_error;
    assign m_service_error   = out_reg.service_error;
    assign m_more_blocks     = out_reg.more_blocks;

endmodule

// ----- rtl/dlms_rhp_checker.sv -----
// ----------------------------------------------------------------------------
// dlms_rhp_checker
// Port-level checks on the result channel of the header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dlms_response_header_parser_top_defines.svh"

module dlms_rhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_header_valid,
    input logic [2:0]  m_service_kind,
    input logic [1:0]  m_response_form,
    input logic [8:0]  m_access_code,
    input logic        m_data_follows,
    input logic [7:0]  m_last_block_flag,
    input logic [31:0] m_block_num,
    input logic        m_more_blocks
);
    import dlms_rhp_pkg::*;

    logic stall;
    logic block_ok;
    logic data_ok;

    assign stall    = m_valid && !m_ready;
    assign block_ok = m_header_valid && (m_response_form == FORM_BLOCK) &&
                      (m_last_block_flag == 8'd0);
    assign data_ok  = (m_service_kind == SVC_ACT) && (m_access_code == ACCESS_SUCCESS);

    `DLMS_ASSERT_NEXT(a_hold, aclk, aresetn, stall, m_valid && $stable(m_block_num))
    `DLMS_ASSERT_NOW(a_valid_svc, aclk, aresetn, m_valid && m_header_valid, m_service_kind != 0)
    `DLMS_ASSERT_NOW(a_more_blocks, aclk, aresetn, m_valid && m_more_blocks, block_ok)
    `DLMS_ASSERT_NOW(a_data_flag, aclk, aresetn, m_valid && m_data_follows, data_ok)

endmodule

bind dlms_response_header_parser_top dlms_rhp_checker u_dlms_rhp_checker (.*);

// ----- test/tb_dlms_response_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_dlms_response_header_parser_top
// Self-checking regression for the DLMS response header parser.
// ----------------------------------------------------------------------------
// APDU bytes are sent over the input channel, and each accepted byte is
// decoded by a local header decoder in the testbench. Every summary transfer
// is checked field by field against the oldest pending header. The tag
// registers are read back after reset, then moved through default, extreme,
// duplicate and random values over the APB port. Traffic runs under three
// idle mixes and one long receiver hold-off.
`timescale 1ns / 1ps

module tb_dlms_response_header_parser_top;

    import dlms_rhp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int PRINT_LIMIT  = 30;

    typedef enum logic [3:0] {
        ST_TAG, ST_KIND, ST_INVOKE, ST_RESULT, ST_GDR_FLAG, ST_CHOICE, ST_ACCESS,
        ST_LAST_BLOCK, ST_BLOCK_NUM, ST_EXC_STATE, ST_EXC_SERVICE
    } hdr_step_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte = '0;
    logic                  s_first_byte = 1'b0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_header_valid;
    logic [2:0]            m_service_kind;
    logic [1:0]            m_response_form;
    logic [7:0]            m_invoke_byte;
    logic [8:0]            m_access_code;
    logic [7:0]            m_action_code;
    logic                  m_data_follows;
    logic [7:0]            m_last_block_flag;
    logic [31:0]           m_block_num;
    logic [7:0]            m_state_error;
    logic [7:0]            m_service_error;
    logic                  m_more_blocks;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // decoder copy of the tag registers and parse state
    tags_t       tag_cfg;
    hdr_step_t   hdr_step;
    logic [2:0]  hdr_svc;
    logic [1:0]  hdr_form;
    logic [7:0]  hdr_invoke;
    logic [8:0]  hdr_access;
    logic [7:0]  hdr_action;
    logic        hdr_data_flag;
    logic [7:0]  hdr_last_blk;
    logic [31:0] hdr_blk_num;
    logic [1:0]  hdr_blk_cnt;
    logic [7:0]  hdr_state_err;
    logic        hdr_idle;

    result_t pending_headers[$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int headers_checked = 0;
    int cycle_count = 0;

    dlms_response_header_parser_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_byte      (s_first_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_header_valid    (m_header_valid),
        .m_service_kind    (m_service_kind),
        .m_response_form   (m_response_form),
        .m_invoke_byte     (m_invoke_byte),
        .m_access_code     (m_access_code),
        .m_action_code     (m_action_code),
        .m_data_follows    (m_data_follows),
        .m_last_block_flag (m_last_block_flag),
        .m_block_num       (m_block_num),
        .m_state_error     (m_state_error),
        .m_service_error   (m_service_error),
        .m_more_blocks     (m_more_blocks),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d headers pending", cycle_count,
                     pending_headers.size());
            $display("dlms_response_header_parser_top regression: fail");
            $finish;
        end
    end

    function automatic bit is_access_code(input logic [7:0] c);
        return (c <= 8'd4) || (c == 8'd9) || (c >= 8'd11 && c <= 8'd19) || (c == 8'd250);
    endfunction

    function automatic bit is_action_code(input logic [7:0] c);
        return (c <= 8'd4) || (c == 8'd9) || (c >= 8'd11 && c <= 8'd16) || (c == 8'd250);
    endfunction

    function automatic void clear_header_fields();
        hdr_step = ST_TAG;
        hdr_svc = SVC_NONE;
        hdr_form = FORM_OTHER;
        hdr_invoke = '0;
        hdr_access = ACCESS_NOT_SET;
        hdr_action = '0;
        hdr_data_flag = 1'b0;
        hdr_last_blk = '0;
        hdr_blk_num = '0;
        hdr_blk_cnt = '0;
        hdr_state_err = '0;
    endfunction

    function automatic void reset_header_decoder();
        tag_cfg.get_tag = GET_TAG_RST;
        tag_cfg.set_tag = SET_TAG_RST;
        tag_cfg.action_tag = ACTION_TAG_RST;
        tag_cfg.exc_tag = EXC_TAG_RST;
        clear_header_fields();
        hdr_idle = 1'b1;
    endfunction

    // Advances the decoder by one byte; returns 1 when a summary is due.
    function automatic bit decode_header_byte(input logic [7:0] d, input bit first,
                                              input bit last, output result_t hdr);
        bit         fin;
        bit         ok;
        logic [7:0] svc_err;
        fin = 1'b0;
        ok = 1'b0;
        svc_err = '0;
        hdr = '0;
        if (first) begin
            clear_header_fields();
            hdr_idle = 1'b0;
        end else if (hdr_idle) begin
            return 1'b0;
        end
        case (hdr_step)
            ST_TAG: begin
                if (d == tag_cfg.get_tag) begin
                    hdr_svc = SVC_GET;
                    hdr_step = ST_KIND;
                end else if (d == tag_cfg.set_tag) begin
                    hdr_svc = SVC_SET;
                    hdr_step = ST_KIND;
                end else if (d == tag_cfg.action_tag) begin
                    hdr_svc = SVC_ACT;
                    hdr_step = ST_KIND;
                end else if (d == tag_cfg.exc_tag) begin
                    hdr_svc = SVC_EXC;
                    hdr_step = ST_EXC_STATE;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_KIND: begin
                hdr_form = (d == RESP_TYPE_NORMAL) ? FORM_NORMAL :
                           (d == RESP_TYPE_BLOCK) ? FORM_BLOCK : FORM_OTHER;
                hdr_step = ST_INVOKE;
            end
            ST_INVOKE: begin
                hdr_invoke = d;
                if (hdr_form == FORM_NORMAL) begin
                    hdr_step = ST_RESULT;
                end else if (hdr_form == FORM_BLOCK) begin
                    hdr_step = ST_LAST_BLOCK;
                end else begin
                    fin = 1'b1;
                    ok = 1'b1;
                end
            end
            ST_RESULT: begin
                if (hdr_svc == SVC_ACT) begin
                    if (is_action_code(d)) begin
                        hdr_action = d;
                        hdr_step = ST_GDR_FLAG;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    fin = 1'b1;
                    if (is_access_code(d)) begin
                        hdr_access = {1'b0, d};
                        ok = 1'b1;
                    end else begin
                        hdr_access = ACCESS_NOT_SET;
                    end
                end
            end
            ST_GDR_FLAG: begin
                if (d == GDR_ABSENT) begin
                    fin = 1'b1;
                    ok = 1'b1;
                end else if (d == GDR_PRESENT) begin
                    hdr_step = ST_CHOICE;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_CHOICE: begin
                if (d == CHOICE_DATA) begin
                    hdr_data_flag = 1'b1;
                    hdr_access = ACCESS_SUCCESS;
                    fin = 1'b1;
                    ok = 1'b1;
                end else if (d == CHOICE_RESULT) begin
                    hdr_step = ST_ACCESS;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_ACCESS: begin
                fin = 1'b1;
                if (is_access_code(d)) begin
                    hdr_access = {1'b0, d};
                    ok = 1'b1;
                end
            end
            ST_LAST_BLOCK: begin
                hdr_last_blk = d;
                hdr_blk_cnt = '0;
                hdr_step = ST_BLOCK_NUM;
            end
            ST_BLOCK_NUM: begin
                hdr_blk_num = {hdr_blk_num[23:0], d};
                if (hdr_blk_cnt == 2'd3) begin
                    hdr_access = ACCESS_SUCCESS;
                    fin = 1'b1;
                    ok = 1'b1;
                end else begin
                    hdr_blk_cnt = hdr_blk_cnt + 2'd1;
                end
            end
            ST_EXC_STATE: begin
                hdr_state_err = d;
                hdr_step = ST_EXC_SERVICE;
            end
            ST_EXC_SERVICE: begin
                svc_err = d;
                fin = 1'b1;
                ok = 1'b1;
            end
            default: begin
                fin = 1'b1;
            end
        endcase
        if (!fin && last)
            fin = 1'b1;
        if (!fin)
            return 1'b0;
        hdr.header_valid = ok;
        hdr.service_kind = hdr_svc;
        hdr.response_form = hdr_form;
        hdr.invoke_byte = hdr_invoke;
        hdr.access_code = hdr_access;
        hdr.action_code = hdr_action;
        hdr.data_follows = hdr_data_flag;
        hdr.last_block_flag = hdr_last_blk;
        hdr.block_num = hdr_blk_num;
        hdr.state_error = hdr_state_err;
        hdr.service_error = svc_err;
        hdr.more_blocks = ok && (hdr_form == FORM_BLOCK) && (hdr_last_blk == 8'd0);
        hdr_idle = 1'b1;
        hdr_step = ST_TAG;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("header %0d %s: got 0x%0h, expected 0x%0h",
                                      headers_checked, name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_headers.size() == 0) begin
                report_mismatch("summary transfer with no header pending");
            end else begin
                want = pending_headers.pop_front();
                headers_checked++;
                check_field("header_valid", 32'(m_header_valid), 32'(want.header_valid));
                check_field("service_kind", 32'(m_service_kind), 32'(want.service_kind));
                check_field("response_form", 32'(m_response_form),
                            32'(want.response_form));
                check_field("invoke_byte", 32'(m_invoke_byte), 32'(want.invoke_byte));
                check_field("access_code", 32'(m_access_code), 32'(want.access_code));
                check_field("action_code", 32'(m_action_code), 32'(want.action_code));
                check_field("data_follows", 32'(m_data_follows), 32'(want.data_follows));
                check_field("last_block_flag", 32'(m_last_block_flag),
                            32'(want.last_block_flag));
                check_field("block_num", m_block_num, want.block_num);
                check_field("state_error", 32'(m_state_error), 32'(want.state_error));
                check_field("service_error", 32'(m_service_error),
                            32'(want.service_error));
                check_field("more_blocks", 32'(m_more_blocks), 32'(want.more_blocks));
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request != 0) begin
                hold_request = 0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_apdu_byte(input logic [7:0] d, input bit first, input bit last);
        result_t hdr;
        int      gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_first_byte <= first;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        if (decode_header_byte(d, first, last, hdr))
            pending_headers.push_back(hdr);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_headers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tag_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [23:0] filler;
        filler = 24'($urandom);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {filler, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_GET_TAG:    tag_cfg.get_tag = value;
            REG_SET_TAG:    tag_cfg.set_tag = value;
            REG_ACTION_TAG: tag_cfg.action_tag = value;
            default:        tag_cfg.exc_tag = value;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_tag_reg(input logic [1:0] idx, input logic [7:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== want)
            report_mismatch($sformatf("tag register %0d read 0x%0h, expected 0x%0h",
                                      idx, prdata[7:0], want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_tags(input logic [7:0] get_t, input logic [7:0] set_t,
                                input logic [7:0] action_t, input logic [7:0] exc_t);
        write_tag_reg(REG_GET_TAG, get_t);
        write_tag_reg(REG_SET_TAG, set_t);
        write_tag_reg(REG_ACTION_TAG, action_t);
        write_tag_reg(REG_EXC_TAG, exc_t);
        read_tag_reg(REG_GET_TAG, get_t);
        read_tag_reg(REG_SET_TAG, set_t);
        read_tag_reg(REG_ACTION_TAG, action_t);
        read_tag_reg(REG_EXC_TAG, exc_t);
    endtask

    function automatic logic [7:0] pick_access_code();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        do c = 8'($urandom); while (!is_access_code(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_action_code();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        do c = 8'($urandom); while (!is_action_code(c));
        return c;
    endfunction

    // Mostly well-formed headers with random content; some are cut short,
    // left unterminated or preceded by stray bytes.
    task automatic send_random_apdu();
        logic [7:0] apdu[$];
        logic [7:0] tag;
        logic [7:0] rtype;
        logic [7:0] flag;
        logic [7:0] choice;
        bit         as_action;
        bit         mark_last;
        int         pick;
        int         len;
        int         i;
        if ($urandom_range(0, 9) == 0) begin
            pick = $urandom_range(1, 3);
            for (i = 0; i < pick; i++)
                send_apdu_byte(8'($urandom), 1'b0, 1'($urandom));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            do tag = 8'($urandom);
            while (tag == tag_cfg.get_tag || tag == tag_cfg.set_tag ||
                   tag == tag_cfg.action_tag || tag == tag_cfg.exc_tag);
            apdu.push_back(tag);
        end else if (pick >= 8) begin
            apdu.push_back(tag_cfg.exc_tag);
            apdu.push_back(8'($urandom));
            apdu.push_back(8'($urandom));
        end else begin
            case (pick)
                1, 2:    tag = tag_cfg.get_tag;
                3, 4:    tag = tag_cfg.set_tag;
                default: tag = tag_cfg.action_tag;
            endcase
            as_action = (tag != tag_cfg.get_tag) && (tag != tag_cfg.set_tag);
            apdu.push_back(tag);
            pick = $urandom_range(0, 9);
            rtype = (pick < 4) ? RESP_TYPE_NORMAL : (pick < 8) ? RESP_TYPE_BLOCK : 8'($urandom);
            apdu.push_back(rtype);
            apdu.push_back(8'($urandom));
            if (rtype == RESP_TYPE_NORMAL && as_action) begin
                apdu.push_back(pick_action_code());
                pick = $urandom_range(0, 9);
                flag = (pick < 4) ? GDR_ABSENT : (pick < 9) ? GDR_PRESENT : 8'($urandom);
                apdu.push_back(flag);
                if (flag == GDR_PRESENT) begin
                    pick = $urandom_range(0, 9);
                    choice = (pick < 4) ? CHOICE_DATA :
                             (pick < 9) ? CHOICE_RESULT : 8'($urandom);
                    apdu.push_back(choice);
                    if (choice == CHOICE_RESULT)
                        apdu.push_back(pick_access_code());
                end
            end else if (rtype == RESP_TYPE_NORMAL) begin
                apdu.push_back(pick_access_code());
            end else if (rtype == RESP_TYPE_BLOCK) begin
                apdu.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                repeat (4) apdu.push_back(8'($urandom));
            end
        end
        pick = $urandom_range(0, 3);
        repeat (pick) apdu.push_back(8'($urandom));
        pick = $urandom_range(0, 9);
        len = (pick < 3) ? $urandom_range(1, apdu.size()) : apdu.size();
        mark_last = (pick != 2);
        for (i = 0; i < len; i++)
            send_apdu_byte(apdu[i], i == 0, mark_last && (i == len - 1));
    endtask

    task automatic test_register_access();
        read_tag_reg(REG_GET_TAG, GET_TAG_RST);
        read_tag_reg(REG_SET_TAG, SET_TAG_RST);
        read_tag_reg(REG_ACTION_TAG, ACTION_TAG_RST);
        read_tag_reg(REG_EXC_TAG, EXC_TAG_RST);
    endtask

    task automatic test_directed_headers();
        // unknown tag
        send_apdu_byte(8'h00, 1'b1, 1'b1);
        // normal get, success
        send_apdu_byte(GET_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(RESP_TYPE_NORMAL, 1'b0, 1'b0);
        send_apdu_byte(8'hFF, 1'b0, 1'b0);
        send_apdu_byte(8'h00, 1'b0, 1'b0);
        // dropped mid-header by a new first byte, then other response type
        send_apdu_byte(SET_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(8'h03, 1'b0, 1'b0);
        send_apdu_byte(SET_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(8'hFF, 1'b0, 1'b0);
        send_apdu_byte(8'h00, 1'b0, 1'b1);
        // action with get-data-result carrying an access result
        send_apdu_byte(ACTION_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(RESP_TYPE_NORMAL, 1'b0, 1'b0);
        send_apdu_byte(8'h81, 1'b0, 1'b0);
        send_apdu_byte(8'h00, 1'b0, 1'b0);
        send_apdu_byte(GDR_PRESENT, 1'b0, 1'b0);
        send_apdu_byte(CHOICE_RESULT, 1'b0, 1'b0);
        send_apdu_byte(8'hFA, 1'b0, 1'b1);
        // data block, not last
        send_apdu_byte(GET_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(RESP_TYPE_BLOCK, 1'b0, 1'b0);
        send_apdu_byte(8'h7E, 1'b0, 1'b0);
        send_apdu_byte(8'h00, 1'b0, 1'b0);
        repeat (4) send_apdu_byte(8'hFF, 1'b0, 1'b0);
        // exception cut short
        send_apdu_byte(EXC_TAG_RST, 1'b1, 1'b0);
        send_apdu_byte(8'hA5, 1'b0, 1'b1);
        drain_results();
    endtask

    task automatic test_random_apdus(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_random_apdu();
        drain_results();
    endtask

    task automatic test_backpressure();
        int i;
        hold_request = 1;
        for (i = 0; i < 40; i++) begin
            if (i % 8 == 0)
                send_random_apdu();
            else
                send_apdu_byte(8'($urandom_range(0, 195)), 1'b1, 1'($urandom));
        end
        drain_results();
    endtask

    task automatic test_tag_priority();
        program_tags(8'h5A, 8'h5A, 8'h5A, 8'h5A);
        test_random_apdus(60);
        program_tags(8'h10, 8'h20, 8'h20, 8'h10);
        test_random_apdus(60);
    endtask

    initial begin
        reset_header_decoder();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_directed_headers();

        src_idle_pct = 17;
        sink_idle_pct = 69;
        test_random_apdus(350);
        test_backpressure();

        program_tags(8'h00, 8'hFF, 8'h01, 8'h80);
        src_idle_pct = 69;
        sink_idle_pct = 17;
        test_random_apdus(350);
        test_tag_priority();

        program_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_apdus(350);

        program_tags(GET_TAG_RST, SET_TAG_RST, ACTION_TAG_RST, EXC_TAG_RST);
        test_random_apdus(60);

        $display("Covered %0d byte transfers and %0d summary transfers in %0d cycles,",
                 bytes_sent, headers_checked, cycle_count);
        $display("over six tag settings, three idle mixes and one receiver hold-off.");
        if (error_count == 0) begin
            $display("dlms_response_header_parser_top regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("dlms_response_header_parser_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dlms_rhp_pkg.sv
rtl/dlms_rhp_cfg.sv
rtl/dlms_rhp_decoder.sv
rtl/dlms_response_header_parser_top.sv
rtl/dlms_rhp_checker.sv
test/tb_dlms_response_header_parser_top.sv
